FILE: rtl/core/sct_pkg.sv
// Shared types, codes and constants of the counting semaphore table.
package sct_pkg;

   // fixed field widths of the request and response transactions
   localparam int KIND_W   = 2;
   localparam int PID_W    = 8;
   localparam int SEM_W    = 4;
   localparam int CNT_W    = 16;
   localparam int STATUS_W = 2;

   // defaults for the top level parameters
   localparam int DEF_NUM_SEMS    = 16;
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_PID_BITS    = 8;

   // allocation flags examined per scan cycle
   localparam int SCAN_W = 8;

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WAIT   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SIGNAL = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd2;

   localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
   localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [PID_W-1:0]        pid;
      logic [SEM_W-1:0]        sem_id;
      logic signed [CNT_W-1:0] init_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SEM_W-1:0]    alloc_id;
      logic                block_caller;
      logic                wake_valid;
      logic [PID_W-1:0]    woken_pid;
   } rsp_type;

   typedef enum logic {
      ALU_DEC,
      ALU_INC
   } alu_op_type;

   typedef struct packed {
      logic signed [CNT_W-1:0] count;
      logic                    negative;
      logic                    non_positive;
      logic                    ring_full;
      logic                    ring_empty;
   } alu_res_type;

   typedef struct packed {
      logic rec_rd;
      logic rec_wr;
      logic ring_rd;
      logic ring_wr;
   } store_ctl_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_sts_type;

endpackage

FILE: rtl/core/sct_alu.sv
// Count and ring pointer arithmetic shared by every wait and signal.
module sct_alu #(
   parameter int QUEUE_DEPTH = sct_pkg::DEF_QUEUE_DEPTH,
   localparam int QW = $clog2(QUEUE_DEPTH)
) (
   input  sct_pkg::alu_op_type         op,
   input  logic signed [sct_pkg::CNT_W-1:0] count,
   input  logic [QW-1:0]               head,
   input  logic [QW-1:0]               tail,
   output logic [QW-1:0]               head_nxt,
   output logic [QW-1:0]               tail_nxt,
   output sct_pkg::alu_res_type        res
);
   import sct_pkg::*;

   localparam logic [QW-1:0] PtrLast = QW'(QUEUE_DEPTH - 1);

   always_comb begin
      unique case (op)
         ALU_INC: res.count = (count == CNT_MAX) ? CNT_MAX : count + 16'sd1;
         ALU_DEC: res.count = (count == CNT_MIN) ? CNT_MIN : count - 16'sd1;
         default: res.count = count;
      endcase
      res.negative     = res.count[CNT_W-1];
      res.non_positive = res.count[CNT_W-1] || (res.count == '0);
      head_nxt         = (head == PtrLast) ? '0 : head + 1'b1;
      tail_nxt         = (tail == PtrLast) ? '0 : tail + 1'b1;
      res.ring_full    = (tail_nxt == head);
      res.ring_empty   = (head == tail);
   end

endmodule

FILE: rtl/core/sct_scan.sv
// Allocation flags and the chunked search for the lowest free entry.
module sct_scan #(
   parameter int NUM_SEMS = sct_pkg::DEF_NUM_SEMS,
   localparam int SemW = $clog2(NUM_SEMS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output sct_pkg::scan_sts_type sts,
   output logic [SemW-1:0]       idx
);
   import sct_pkg::*;

   localparam int NChunk = (NUM_SEMS + SCAN_W - 1) / SCAN_W;
   localparam int ChW    = (NChunk > 1) ? $clog2(NChunk) : 1;
   localparam int PadN   = NChunk * SCAN_W;
   localparam int PosW   = $clog2(SCAN_W);

   logic [NUM_SEMS-1:0] entry_valid_ff, entry_valid_in;
   logic [ChW-1:0]      chunk_ff, chunk_in;
   logic                active_ff, active_in;
   logic [PadN-1:0]     used_pad;
   logic [SCAN_W-1:0]   bits;
   logic [PosW-1:0]     pos;
   logic                any_free;
   logic                last_chunk;

   always_comb begin
      used_pad                 = '1;
      used_pad[NUM_SEMS-1:0]   = entry_valid_ff;
      bits                     = used_pad[chunk_ff*SCAN_W +: SCAN_W];
      pos                      = '0;
      any_free                 = 1'b0;
      for (int i = SCAN_W - 1; i >= 0; i--) begin
         if (!bits[i]) begin
            pos      = PosW'(i);
            any_free = 1'b1;
         end
      end
      last_chunk = (chunk_ff == ChW'(NChunk - 1));
      idx        = SemW'({chunk_ff, pos});
      sts.found  = active_ff && any_free;
      sts.done   = active_ff && (any_free || last_chunk);

      entry_valid_in = entry_valid_ff;
      chunk_in       = chunk_ff;
      active_in      = active_ff;
      if (start) begin
         active_in = 1'b1;
         chunk_in  = '0;
      end else if (active_ff) begin
         if (sts.done) begin
            active_in = 1'b0;
         end else begin
            chunk_in = chunk_ff + 1'b1;
         end
         if (sts.found) begin
            entry_valid_in[idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         chunk_ff       <= '0;
         active_ff      <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         chunk_ff       <= chunk_in;
         active_ff      <= active_in;
      end
   end

endmodule

FILE: rtl/core/sct_store.sv
// Per-entry record memory (count, head, tail) and the wait ring memory.
module sct_store #(
   parameter int NUM_SEMS    = sct_pkg::DEF_NUM_SEMS,
   parameter int QUEUE_DEPTH = sct_pkg::DEF_QUEUE_DEPTH,
   parameter int PID_STORE_W = sct_pkg::DEF_PID_BITS,
   localparam int SemW = $clog2(NUM_SEMS),
   localparam int QW   = $clog2(QUEUE_DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sct_pkg::store_ctl_type            ctl,
   input  logic [SemW-1:0]                   rec_rd_idx,
   input  logic [SemW-1:0]                   rec_wr_idx,
   input  logic signed [sct_pkg::CNT_W-1:0]  wr_count,
   input  logic [QW-1:0]                     wr_head,
   input  logic [QW-1:0]                     wr_tail,
   output logic signed [sct_pkg::CNT_W-1:0]  rd_count,
   output logic [QW-1:0]                     rd_head,
   output logic [QW-1:0]                     rd_tail,
   input  logic [SemW-1:0]                   ring_sem,
   input  logic [QW-1:0]                     ring_ptr,
   input  logic [PID_STORE_W-1:0]            ring_wr_pid,
   output logic [PID_STORE_W-1:0]            ring_rd_pid
);
   import sct_pkg::*;

   localparam int RecW = CNT_W + 2 * QW;

   logic [RecW-1:0]        rec_mem [NUM_SEMS];
   logic [PID_STORE_W-1:0] ring_mem [NUM_SEMS][QUEUE_DEPTH];
   logic [NUM_SEMS-1:0]    touched_ff;
   logic                   hit_ff;
   logic [RecW-1:0]        rec_q_ff;
   logic [RecW-1:0]        rec_view;
   logic [PID_STORE_W-1:0] ring_q_ff;

   // untouched entries read as their reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff <= '0;
      end else if (ctl.rec_wr) begin
         touched_ff[rec_wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rec_wr) begin
         rec_mem[rec_wr_idx] <= {wr_count, wr_head, wr_tail};
      end
      if (ctl.rec_rd) begin
         rec_q_ff <= rec_mem[rec_rd_idx];
         hit_ff   <= touched_ff[rec_rd_idx];
      end
   end

   // ring slots are only read between head and tail, so never before a write
   always_ff @(posedge clock) begin
      if (ctl.ring_wr) begin
         ring_mem[ring_sem][ring_ptr] <= ring_wr_pid;
      end
      if (ctl.ring_rd) begin
         ring_q_ff <= ring_mem[ring_sem][ring_ptr];
      end
   end

   assign rec_view    = hit_ff ? rec_q_ff : '0;
   assign rd_count    = rec_view[RecW-1 -: CNT_W];
   assign rd_head     = rec_view[2*QW-1 -: QW];
   assign rd_tail     = rec_view[QW-1:0];
   assign ring_rd_pid = ring_q_ff;

endmodule

FILE: rtl/core/counting_semaphore_table.sv
// Counting semaphore table with a FIFO wait ring per entry: sequencer and response register.
// Sequence: wait and signal pass S_EXEC then S_FINISH after the accept; a signal that wakes
//   a waiter also passes S_RING; allocate first scans in S_SCAN (8 allocation flags per cycle).
// Throughput: one transaction at a time; req_ready returns when the response is loaded,
//   and the record and ring memory reads are registered.
// Reset: synchronous, active high; all entries free, counts and ring pointers read as zero.
module counting_semaphore_table #(
   parameter int NUM_SEMS    = sct_pkg::DEF_NUM_SEMS,
   parameter int QUEUE_DEPTH = sct_pkg::DEF_QUEUE_DEPTH,
   parameter int PID_BITS    = sct_pkg::DEF_PID_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sct_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sct_pkg::rsp_type rsp_data
);
   import sct_pkg::*;

   localparam int SemW   = $clog2(NUM_SEMS);
   localparam int QW     = $clog2(QUEUE_DEPTH);
   // only the low PID_BITS of a pid are kept, never more than the field has
   localparam int PidW   = (PID_BITS < PID_W) ? PID_BITS : PID_W;
   localparam int CmpW   = ((SEM_W > SemW) ? SEM_W : SemW) + 1;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_RING   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]      state_ff, state_in;
   req_type         req_ff, req_in;
   logic [SemW-1:0] sem_ff, sem_in;
   rsp_type         res_ff, res_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic            req_fire;
   logic            in_range;
   logic            scan_start;
   scan_sts_type    scan_sts;
   logic [SemW-1:0] scan_idx;

   store_ctl_type           st_ctl;
   logic [SemW-1:0]         rec_rd_idx;
   logic signed [CNT_W-1:0] rd_count, wr_count;
   logic [QW-1:0]           rd_head, rd_tail, wr_head, wr_tail;
   logic [QW-1:0]           ring_ptr;
   logic [PidW-1:0]         ring_rd_pid;

   alu_op_type              alu_op;
   alu_res_type             alu_res;
   logic [QW-1:0]           head_nxt, tail_nxt;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign in_range  = (CmpW'(req_data.sem_id) < CmpW'(NUM_SEMS));

   // signal counts up, everything else that reaches the unit counts down
   assign alu_op = (req_ff.kind == KIND_SIGNAL) ? ALU_INC : ALU_DEC;

   sct_alu #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_alu (
      .op       (alu_op),
      .count    (rd_count),
      .head     (rd_head),
      .tail     (rd_tail),
      .head_nxt (head_nxt),
      .tail_nxt (tail_nxt),
      .res      (alu_res)
   );

   sct_scan #(
      .NUM_SEMS(NUM_SEMS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .start (scan_start),
      .sts   (scan_sts),
      .idx   (scan_idx)
   );

   sct_store #(
      .NUM_SEMS    (NUM_SEMS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PID_STORE_W (PidW)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (st_ctl),
      .rec_rd_idx  (rec_rd_idx),
      .rec_wr_idx  (sem_ff),
      .wr_count    (wr_count),
      .wr_head     (wr_head),
      .wr_tail     (wr_tail),
      .rd_count    (rd_count),
      .rd_head     (rd_head),
      .rd_tail     (rd_tail),
      .ring_sem    (sem_ff),
      .ring_ptr    (ring_ptr),
      .ring_wr_pid (PidW'(req_ff.pid)),
      .ring_rd_pid (ring_rd_pid)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      sem_in       = sem_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      scan_start   = 1'b0;
      st_ctl       = '0;
      rec_rd_idx   = scan_idx;
      wr_count     = alu_res.count;
      wr_head      = rd_head;
      wr_tail      = rd_tail;
      ring_ptr     = rd_tail;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            rec_rd_idx = SemW'(req_data.sem_id);
            if (req_fire) begin
               req_in = req_data;
               sem_in = SemW'(req_data.sem_id);
               res_in = '0;
               if (req_data.kind == KIND_ALLOC) begin
                  scan_start = 1'b1;
                  state_in   = S_SCAN;
               end else if ((req_data.kind == KIND_WAIT || req_data.kind == KIND_SIGNAL)
                            && in_range) begin
                  st_ctl.rec_rd = 1'b1;
                  state_in      = S_EXEC;
               end else begin
                  // unknown kind or entry outside the table: all-zero response
                  state_in = S_FINISH;
               end
            end
         end

         S_SCAN: begin
            if (scan_sts.done) begin
               if (scan_sts.found) begin
                  // fetch the record so the ring pointers survive the allocate
                  st_ctl.rec_rd = 1'b1;
                  sem_in        = scan_idx;
                  state_in      = S_EXEC;
               end else begin
                  res_in.status = ST_NO_FREE;
                  state_in      = S_FINISH;
               end
            end
         end

         S_EXEC: begin
            state_in = S_FINISH;
            unique case (req_ff.kind)
               KIND_ALLOC: begin
                  st_ctl.rec_wr   = 1'b1;
                  wr_count        = req_ff.init_value;
                  res_in.alloc_id = SEM_W'(sem_ff);
               end
               KIND_WAIT: begin
                  if (alu_res.negative) begin
                     if (alu_res.ring_full) begin
                        // refused: count and ring untouched
                        res_in.status = ST_QUEUE_FULL;
                     end else begin
                        st_ctl.rec_wr       = 1'b1;
                        st_ctl.ring_wr      = 1'b1;
                        ring_ptr            = rd_tail;
                        wr_tail             = tail_nxt;
                        res_in.block_caller = 1'b1;
                     end
                  end else begin
                     st_ctl.rec_wr = 1'b1;
                  end
               end
               KIND_SIGNAL: begin
                  st_ctl.rec_wr = 1'b1;
                  if (alu_res.non_positive && !alu_res.ring_empty) begin
                     // dequeue oldest waiter; its pid arrives next cycle
                     st_ctl.ring_rd = 1'b1;
                     ring_ptr       = rd_head;
                     wr_head        = head_nxt;
                     state_in       = S_RING;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end

         S_RING: begin
            res_in.wake_valid = 1'b1;
            res_in.woken_pid  = PID_W'(ring_rd_pid);
            state_in          = S_FINISH;
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      sem_ff <= sem_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
